FILE: rtl/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg
// Shared types and constants for the auto-brightness ramp block.
// ----------------------------------------------------------------------------
package abr_pkg;

  localparam int SENSOR_BITS_DEF = 12;
  localparam int SENSOR_REG_W    = 12;
  localparam int BRIGHT_W        = 8;
  localparam int RAMP_W          = 16;
  localparam int TIME_W          = 32;
  localparam int OP_W            = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FORCE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TOTAL = 3'd5;

  // reset values
  localparam logic [SENSOR_REG_W-1:0] RST_SENSOR_MIN = 12'd0;
  localparam logic [SENSOR_REG_W-1:0] RST_SENSOR_MAX = 12'd4095;
  localparam logic [BRIGHT_W-1:0]     RST_BRIGHT_MIN = 8'd1;
  localparam logic [BRIGHT_W-1:0]     RST_BRIGHT_MAX = 8'd100;
  localparam logic [BRIGHT_W-1:0]     RST_THRESHOLD  = 8'd2;
  localparam logic [RAMP_W-1:0]       RST_RAMP_TOTAL = 16'd1000;
  localparam logic [BRIGHT_W-1:0]     RST_CURRENT    = 8'd10;
  localparam logic [BRIGHT_W-1:0]     RST_TARGET     = 8'd0;

  localparam logic [BRIGHT_W-1:0]     LEVEL_STEP     = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_DIFF,
    S_DIV2,
    S_WB
  } state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

FILE: rtl/abr_mul.sv
// ----------------------------------------------------------------------------
// abr_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module abr_mul #(
  parameter int AW = 12,
  parameter int BW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       mcand,
  input  logic [BW-1:0]       mplier,
  output logic [AW+BW-1:0]    product,
  output abr_pkg::unit_sts_t  sts
);
  import abr_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [PW-1:0] prod_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [AW:0]   sum;
  logic [PW-1:0] prod_nxt;

  // upper half accumulates, the whole word shifts right one bit per step
  assign sum      = {1'b0, prod_r[PW-1:BW]} + (prod_r[0] ? {1'b0, a_r} : '0);
  assign prod_nxt = {sum, prod_r[BW-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= mcand;
      prod_r <= {{AW{1'b0}}, mplier};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign product  = prod_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/abr_div.sv
// ----------------------------------------------------------------------------
// abr_div
// Restoring divider, one quotient bit per cycle. The upper DW-QN bits of the
// dividend must already be below the divisor, so QN steps give the quotient.
// ----------------------------------------------------------------------------
module abr_div #(
  parameter int DW = 20,
  parameter int VW = 12,
  parameter int QN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic [QN-1:0]       quotient,
  output abr_pkg::unit_sts_t  sts
);
  import abr_pkg::*;

  localparam int CW = $clog2(QN + 1);
  localparam int EW = VW + DW - QN;

  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;
  logic [QN-1:0] dvd_r;
  logic [QN-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;
  logic [EW-1:0] rem_init;

  assign trial    = {rem_r, dvd_r[QN-1]};
  assign diff     = trial - {1'b0, dsr_r};
  assign ge       = trial >= {1'b0, dsr_r};
  assign rem_nxt  = ge ? diff[VW-1:0] : trial[VW-1:0];
  assign rem_init = {{VW{1'b0}}, dividend[DW-1:QN]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QN);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init[VW-1:0];
      dsr_r <= divisor;
      dvd_r <= dividend[QN-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[QN-2:0], 1'b0};
      q_r   <= {q_r[QN-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/auto_brightness_ramp.sv
// ----------------------------------------------------------------------------
// auto_brightness_ramp
// Ambient-light driven brightness target with a timed one-step ramp.
//
// A sensor sample goes through a bit-serial multiply of the clamped
// sample offset by the brightness span, a restoring divide by the sensor
// span, a step that forms the difference, and a divide of ramp_total by
// that difference, then write-back. A sample with an empty sensor span
// skips the multiply and the first divide, and one with a difference of
// zero or below threshold skips the last divide. Ticks, forced sets and
// the unused op go straight to write-back. One transaction is worked on at a
// time; the result sits in an output register, and the next transaction is
// accepted while it waits. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module auto_brightness_ramp #(
  parameter int SENSOR_BITS = abr_pkg::SENSOR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [abr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abr_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [abr_pkg::OP_W-1:0]        in_op,
  input  logic [SENSOR_BITS-1:0]          in_light,
  input  logic [abr_pkg::TIME_W-1:0]      in_time_now,
  input  logic [abr_pkg::BRIGHT_W-1:0]    in_set_level,
  input  logic                            in_also_target,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [abr_pkg::BRIGHT_W-1:0]    out_brightness,
  output logic [abr_pkg::BRIGHT_W-1:0]    out_goal,
  output logic                            out_ramping,
  output logic                            out_refresh
);
  import abr_pkg::*;

  localparam int SW = SENSOR_BITS;
  localparam int BW = BRIGHT_W;
  localparam int PW = SW + BW;

  // configuration registers
  logic [SENSOR_REG_W-1:0] sensor_min_r;
  logic [SENSOR_REG_W-1:0] sensor_max_r;
  logic [BW-1:0]           bright_min_r;
  logic [BW-1:0]           bright_max_r;
  logic [BW-1:0]           threshold_r;
  logic [RAMP_W-1:0]       ramp_total_r;

  // architectural state
  logic [BW-1:0]     cur_r;
  logic [BW-1:0]     tgt_r;
  logic              down_r;
  logic [RAMP_W-1:0] period_r;
  logic [TIME_W-1:0] last_r;

  // values pending commit at write-back
  logic [BW-1:0]     p_cur_r;
  logic [BW-1:0]     p_tgt_r;
  logic              p_down_r;
  logic [RAMP_W-1:0] p_period_r;
  logic [TIME_W-1:0] p_last_r;
  logic              p_refresh_r;
  logic [BW-1:0]     off_r;

  logic          out_valid_r;
  logic [BW-1:0] out_bright_r;
  logic [BW-1:0] out_goal_r;
  logic          out_refresh_r;

  state_t state_r, state_nxt;

  // sensor window, masked to the sensor width
  logic [SW+SENSOR_REG_W-1:0] lo_ext, hi_ext;
  logic [SW-1:0] lo, hi, xc, xo, span;
  logic          span_empty;
  logic          up_map;
  logic [BW-1:0] mag;

  assign lo_ext     = {{SW{1'b0}}, sensor_min_r};
  assign hi_ext     = {{SW{1'b0}}, sensor_max_r};
  assign lo         = lo_ext[SW-1:0];
  assign hi         = hi_ext[SW-1:0];
  assign span_empty = hi <= lo;
  assign xc         = (in_light < lo) ? lo : ((in_light > hi) ? hi : in_light);
  assign xo         = xc - lo;
  assign span       = hi - lo;
  assign up_map     = bright_max_r >= bright_min_r;
  assign mag        = up_map ? (bright_max_r - bright_min_r) : (bright_min_r - bright_max_r);

  // target, difference and ramp decision
  logic [BW-1:0] map_tgt, diff;
  logic          ramp_go;

  assign map_tgt = up_map ? (bright_min_r + off_r) : (bright_min_r - off_r);
  assign diff    = (map_tgt >= cur_r) ? (map_tgt - cur_r) : (cur_r - map_tgt);
  assign ramp_go = (diff != '0) && (diff >= threshold_r);

  // tick timing, elapsed wraps modulo 2^32
  logic [TIME_W-1:0] elapsed;
  logic              step_ok;

  assign elapsed = in_time_now - last_r;
  assign step_ok = (cur_r != tgt_r) && (elapsed >= {{(TIME_W-RAMP_W){1'b0}}, period_r});

  // serial units
  logic                in_accept;
  logic                mul_start, div1_start, div2_start, wb_fire;
  logic [PW-1:0]       mul_prod;
  logic [BW-1:0]       div1_q;
  logic [RAMP_W-1:0]   div2_q;
  unit_sts_t           mul_sts, div1_sts, div2_sts;

  abr_mul #(.AW(SW), .BW(BW)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (xo),
    .mplier  (mag),
    .product (mul_prod),
    .sts     (mul_sts)
  );

  // quotient is at most mag, so 8 steps cover it
  abr_div #(.DW(PW), .VW(SW), .QN(BW)) u_div_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div1_start),
    .dividend (mul_prod),
    .divisor  (span),
    .quotient (div1_q),
    .sts      (div1_sts)
  );

  abr_div #(.DW(RAMP_W + 1), .VW(BW), .QN(RAMP_W)) u_div_period (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div2_start),
    .dividend ({1'b0, ramp_total_r}),
    .divisor  (diff),
    .quotient (div2_q),
    .sts      (div2_sts)
  );

  // control
  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    in_accept  = 1'b0;
    mul_start  = 1'b0;
    div1_start = 1'b0;
    div2_start = 1'b0;
    wb_fire    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        in_accept = in_valid;
        if (in_valid) begin
          if (in_op == OP_SAMPLE) begin
            if (span_empty) begin
              state_nxt = S_DIFF;
            end else begin
              mul_start = 1'b1;
              state_nxt = S_MUL;
            end
          end else begin
            state_nxt = S_WB;
          end
        end
      end
      S_MUL: begin
        if (mul_sts.done) begin
          div1_start = 1'b1;
          state_nxt  = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div1_sts.done) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (ramp_go) begin
          div2_start = 1'b1;
          state_nxt  = S_DIV2;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_DIV2: begin
        if (div2_sts.done) state_nxt = S_WB;
      end
      S_WB: begin
        if (!out_valid_r || !out_stall) begin
          wb_fire   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_min_r <= RST_SENSOR_MIN;
      sensor_max_r <= RST_SENSOR_MAX;
      bright_min_r <= RST_BRIGHT_MIN;
      bright_max_r <= RST_BRIGHT_MAX;
      threshold_r  <= RST_THRESHOLD;
      ramp_total_r <= RST_RAMP_TOTAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENSOR_MIN: sensor_min_r <= cfg_data[SENSOR_REG_W-1:0];
        REG_SENSOR_MAX: sensor_max_r <= cfg_data[SENSOR_REG_W-1:0];
        REG_BRIGHT_MIN: bright_min_r <= cfg_data[BW-1:0];
        REG_BRIGHT_MAX: bright_max_r <= cfg_data[BW-1:0];
        REG_THRESHOLD:  threshold_r  <= cfg_data[BW-1:0];
        REG_RAMP_TOTAL: ramp_total_r <= cfg_data[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  // architectural state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= RST_CURRENT;
      tgt_r       <= RST_TARGET;
      down_r      <= 1'b0;
      period_r    <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_fire) begin
        cur_r       <= p_cur_r;
        tgt_r       <= p_tgt_r;
        down_r      <= p_down_r;
        period_r    <= p_period_r;
        last_r      <= p_last_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_bright_r  <= p_cur_r;
      out_goal_r    <= p_tgt_r;
      out_refresh_r <= p_refresh_r;
    end
  end

  // pending results of the transaction in flight
  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_cur_r     <= cur_r;
      p_tgt_r     <= tgt_r;
      p_down_r    <= down_r;
      p_period_r  <= period_r;
      p_last_r    <= last_r;
      p_refresh_r <= 1'b0;
      off_r       <= '0;
      case (in_op)
        OP_TICK: begin
          if (step_ok) begin
            p_last_r    <= in_time_now;
            p_cur_r     <= down_r ? (cur_r - LEVEL_STEP) : (cur_r + LEVEL_STEP);
            p_refresh_r <= 1'b1;
          end
        end
        OP_FORCE: begin
          p_cur_r     <= in_set_level;
          p_refresh_r <= 1'b1;
          if (in_also_target) p_tgt_r <= in_set_level;
        end
        default: ;
      endcase
    end else begin
      if (state_r == S_DIV1 && div1_sts.done) off_r <= div1_q;
      if (state_r == S_DIFF) begin
        if (ramp_go) begin
          p_tgt_r  <= map_tgt;
          p_down_r <= !(map_tgt > cur_r);
        end else begin
          p_tgt_r <= cur_r;
        end
      end
      if (state_r == S_DIV2 && div2_sts.done) p_period_r <= div2_q;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = out_bright_r;
  assign out_goal       = out_goal_r;
  assign out_ramping    = out_bright_r != out_goal_r;
  assign out_refresh    = out_refresh_r;

  // the serial units run strictly one after another
  a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_sts.busy, div1_sts.busy, div2_sts.busy}))
    else $error("more than one serial unit busy");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> state_r == S_MUL)
    else $error("multiplier finished outside its state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div1_sts.done |-> state_r == S_DIV1) and (div2_sts.done |-> state_r == S_DIV2))
    else $error("divider finished outside its state");

  // a result lands in the register together with the committed state
  a_wb_commit: assert property (@(posedge clk) disable iff (!rst_n)
    wb_fire |=> out_valid_r && out_bright_r == cur_r && out_goal_r == tgt_r)
    else $error("result register out of step with committed state");

endmodule
